@@ design/life_cellular_automaton_step_core_defines.svh @@
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_core_defines: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_STEP_CORE_DEFINES_SVH
`define LIFE_CELLULAR_AUTOMATON_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define LIFE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/life_pkg.sv @@
// ----------------------------------------------------------------------------
// life_pkg: shared types, constants and the B3/S23 rule
// field widths, register codes, reset values and the neighbour rule
// ----------------------------------------------------------------------------
package life_pkg;

    localparam int ROW_COUNT_W = 11;
    localparam int COL_COUNT_W = 12;
    localparam int CELL_ROW_W  = 11;
    localparam int CELL_COL_W  = 11;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = CFG_INDEX_W'(1);

    localparam int ROW_COUNT_RST = 100;
    localparam int COL_COUNT_RST = 2000;
    localparam int MIN_COLS      = 3;

    localparam int MAX_COLS_DEF = 2048;
    localparam int MAX_ROWS_DEF = 1024;

    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    // one column of the 3x3 neighbourhood: [0] row above, [1] centre row, [2] row below
    typedef logic [2:0] column_t;

    function automatic logic life_rule(column_t left, column_t centre, column_t right);
        logic [3:0] count;
        count = 4'(left[0]) + 4'(left[1]) + 4'(left[2])
              + 4'(centre[0]) + 4'(centre[2])
              + 4'(right[0]) + 4'(right[1]) + 4'(right[2]);
        if (centre[1])
            return (count == SURVIVE_MIN) || (count == BIRTH_COUNT);
        return count == BIRTH_COUNT;
    endfunction

endpackage

@@ design/life_ram.sv @@
// ----------------------------------------------------------------------------
// life_ram: generic single-port-write, single-port-read memory
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module life_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/life_cellular_automaton_step_core.sv @@
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_core: B3/S23 next generation over a streamed row block
// pipeline: a result passes the stage 1 registers, the stage 2 job register and the output register
// throughput: one cell per cycle; a row's last cell gives three results, one a cycle,
//   which drain while columns 0 and 1 of the next row give none, so only out_stall holds the input
// reset: async active low; positions clear, row_count 100, col_count 2000, row store kept
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_step_core_defines.svh"

module life_cellular_automaton_step_core
    import life_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // current generation cells, raster order
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   alive,

    // next generation results
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   next_alive,
    output logic [CELL_ROW_W-1:0]  cell_row,
    output logic [CELL_COL_W-1:0]  cell_col,
    output logic                   run_last
);

    // widths of the position counters
    localparam int RW     = $clog2(MAX_ROWS + 2);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int RCMP_W = (RW > ROW_COUNT_W) ? RW : ROW_COUNT_W;
    localparam int CCMP_W = (CW + 1 > COL_COUNT_W) ? CW + 1 : COL_COUNT_W;

    // reset values of the clamped limits
    localparam int ROW_EFF_RST = (ROW_COUNT_RST < 1) ? 1 :
                                 (ROW_COUNT_RST > MAX_ROWS) ? MAX_ROWS : ROW_COUNT_RST;
    localparam int COL_EFF_RST = (COL_COUNT_RST < MIN_COLS) ? MIN_COLS :
                                 (COL_COUNT_RST > MAX_COLS) ? MAX_COLS : COL_COUNT_RST;
    localparam logic [RW-1:0] ROW_LAST_RST = RW'(ROW_EFF_RST + 1);
    localparam logic [CW-1:0] COL_LAST_RST = CW'(COL_EFF_RST - 1);

    // a row store word keeps two rows of one column: [1] previous row, [0] the row before
    localparam int WORD_W = 2;

    // result job: columns c-2, c-1, c of the current row triple plus saved columns 0 and 1
    typedef struct packed {
        column_t                a;
        column_t                b;
        column_t                c;
        column_t                z0;
        column_t                z1;
        logic [CELL_ROW_W-1:0]  row;
        logic [CW-1:0]          col;
    } job_t;

    // ------------------------------------------------------------------------
    // configuration: limits are kept already clamped, as the halo row index
    // and the last column index
    // ------------------------------------------------------------------------
    logic              cfg_acc;
    logic [RW-1:0]     row_last_reg;
    logic [CW-1:0]     col_last_reg;
    logic [RW-1:0]     row_last_next;
    logic [CW-1:0]     col_last_next;
    logic [RCMP_W-1:0] row_req;
    logic [RCMP_W-1:0] row_eff;
    logic [CCMP_W-1:0] col_req;
    logic [CCMP_W-1:0] col_eff;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;

    always_comb
    begin
        row_req = RCMP_W'(cfg_data[ROW_COUNT_W-1:0]);
        if (row_req == '0)
            row_eff = RCMP_W'(1);
        else if (row_req > RCMP_W'(MAX_ROWS))
            row_eff = RCMP_W'(MAX_ROWS);
        else
            row_eff = row_req;
        row_last_next = RW'(row_eff) + RW'(1);

        col_req = CCMP_W'(cfg_data[COL_COUNT_W-1:0]);
        if (col_req < CCMP_W'(MIN_COLS))
            col_eff = CCMP_W'(MIN_COLS);
        else if (col_req > CCMP_W'(MAX_COLS))
            col_eff = CCMP_W'(MAX_COLS);
        else
            col_eff = col_req;
        col_last_next = CW'(col_eff - CCMP_W'(1));
    end

    // ------------------------------------------------------------------------
    // stage 0: accept a cell, step the raster position, start the store read
    // ------------------------------------------------------------------------
    logic          in_acc;
    logic [RW-1:0] row_pos_reg;
    logic [CW-1:0] col_pos_reg;
    logic [CW-1:0] col_eff_pos;
    logic          at_last;
    logic          row_ok;

    assign in_acc      = in_valid && !in_stall;
    // position beyond the last column counts as the last column
    assign col_eff_pos = (col_pos_reg > col_last_reg) ? col_last_reg : col_pos_reg;
    assign at_last     = (col_eff_pos == col_last_reg);
    // rows 0 and 1 have no complete neighbourhood above them yet
    assign row_ok      = (row_pos_reg >= RW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_last_reg <= ROW_LAST_RST;
            col_last_reg <= COL_LAST_RST;
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
        end
        else if (cfg_acc)
        begin
            // a write to either register restarts the block
            case (cfg_index)
                REG_ROW_COUNT:
                begin
                    row_last_reg <= row_last_next;
                    row_pos_reg  <= '0;
                    col_pos_reg  <= '0;
                end
                REG_COL_COUNT:
                begin
                    col_last_reg <= col_last_next;
                    row_pos_reg  <= '0;
                    col_pos_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_acc)
        begin
            if (at_last)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= (row_pos_reg >= row_last_reg) ? '0 : row_pos_reg + RW'(1);
            end
            else
            begin
                col_pos_reg <= col_eff_pos + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stage 1: store word arrives, the row store is updated and the window shifts
    // ------------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_alive_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [CELL_ROW_W-1:0] s1_row_reg;
    logic                  s1_mid_reg;
    logic                  s1_wrap_reg;
    logic [WORD_W-1:0]     rd_word;
    column_t               new_col;
    logic                  s1_need;
    logic                  s1_adv;
    logic                  s2_take;

    life_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_COLS)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_alive_reg, rd_word[1]}),
        .rd_en   (in_acc),
        .rd_addr (col_eff_pos),
        .rd_data (rd_word)
    );

    assign new_col  = {s1_alive_reg, rd_word[1], rd_word[0]};
    assign s1_need  = s1_mid_reg || s1_wrap_reg;
    // cells that give no result only update the store and the window
    assign s1_adv   = s1_valid_reg && (!s1_need || s2_take);
    assign in_stall = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_alive_reg <= alive;
            s1_col_reg   <= col_eff_pos;
            s1_row_reg   <= CELL_ROW_W'(row_pos_reg - RW'(1));
            s1_mid_reg   <= row_ok && (col_eff_pos >= CW'(2));
            s1_wrap_reg  <= row_ok && at_last;
        end
    end

    // the two columns before the incoming one and the first two columns of the current row
    column_t win_reg [2];
    column_t col0_reg;
    column_t col1_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= new_col;
            if (s1_col_reg == '0)
                col0_reg <= new_col;
            if (s1_col_reg == CW'(1))
                col1_reg <= new_col;
        end
    end

    // ------------------------------------------------------------------------
    // stage 2: a job gives one or three results, one a cycle while out_stall is low
    // pending bits: [0] column c-1, [1] last column, [2] column 0
    // ------------------------------------------------------------------------
    logic                  s2_valid_reg;
    logic [2:0]            s2_pend_reg;
    job_t                  s2_job_reg;
    logic                  s2_one;
    logic                  out_free;
    logic                  out_load;
    logic                  s2_done;
    column_t               sel_l;
    column_t               sel_c;
    column_t               sel_r;
    logic [CW-1:0]         sel_col;

    assign s2_one   = (s2_pend_reg == 3'b001) || (s2_pend_reg == 3'b010) ||
                      (s2_pend_reg == 3'b100);
    assign out_free = !out_valid || !out_stall;
    assign out_load = s2_valid_reg && out_free;
    assign s2_done  = out_load && s2_one;
    assign s2_take  = !s2_valid_reg || s2_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_pend_reg  <= '0;
        end
        else if (s1_adv && s1_need)
        begin
            s2_valid_reg <= 1'b1;
            s2_pend_reg  <= {s1_wrap_reg, s1_wrap_reg, s1_mid_reg};
        end
        else if (s2_done)
        begin
            s2_valid_reg <= 1'b0;
            s2_pend_reg  <= '0;
        end
        else if (out_load)
        begin
            // drop the result just issued
            s2_pend_reg <= s2_pend_reg & (s2_pend_reg - 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_need)
        begin
            s2_job_reg.a   <= win_reg[0];
            s2_job_reg.b   <= win_reg[1];
            s2_job_reg.c   <= new_col;
            s2_job_reg.z0  <= col0_reg;
            s2_job_reg.z1  <= col1_reg;
            s2_job_reg.row <= s1_row_reg;
            s2_job_reg.col <= s1_col_reg;
        end
    end

    // pick the neighbourhood of the oldest pending result
    always_comb
    begin
        if (s2_pend_reg[0])
        begin
            sel_l   = s2_job_reg.a;
            sel_c   = s2_job_reg.b;
            sel_r   = s2_job_reg.c;
            sel_col = s2_job_reg.col - CW'(1);
        end
        else if (s2_pend_reg[1])
        begin
            // last column wraps to column 0 on its right
            sel_l   = s2_job_reg.b;
            sel_c   = s2_job_reg.c;
            sel_r   = s2_job_reg.z0;
            sel_col = s2_job_reg.col;
        end
        else
        begin
            // column 0 wraps to the last column on its left
            sel_l   = s2_job_reg.c;
            sel_c   = s2_job_reg.z0;
            sel_r   = s2_job_reg.z1;
            sel_col = '0;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    logic out_valid_reg;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            next_alive <= life_rule(sel_l, sel_c, sel_r);
            cell_row   <= s2_job_reg.row;
            cell_col   <= CELL_COL_W'(sel_col);
            run_last   <= s2_one;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `LIFE_ASSERT_IMPLIES(a_col_in_range, 1'b1, col_pos_reg <= col_last_reg,
        "column position beyond the last column")
    `LIFE_ASSERT_IMPLIES(a_row_in_range, 1'b1, row_pos_reg <= row_last_reg,
        "row position beyond the lower halo row")
    `LIFE_ASSERT_IMPLIES(a_job_pending, s2_valid_reg, s2_pend_reg != 3'b000,
        "result job held with nothing pending")
    `LIFE_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !run_last, out_valid,
        "result run broken before its last item")

endmodule

@@ bench/life_step_checker.sv @@
// ----------------------------------------------------------------------------
// life_step_checker: next-generation predictor and result scoreboard
// watches the register, cell and result channels of the life step core,
// keeps its own three-row store and positions, works out the B3/S23 result
// cells for every accepted item and compares each result field by field
// ----------------------------------------------------------------------------
module life_step_checker
    import life_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   alive,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   next_alive,
    input  logic [CELL_ROW_W-1:0]  cell_row,
    input  logic [CELL_COL_W-1:0]  cell_col,
    input  logic                   run_last,
    output int                     mismatch_count,
    output int                     results_waiting,
    output int                     results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                  next_alive;
        logic [CELL_ROW_W-1:0] row;
        logic [CELL_COL_W-1:0] col;
        logic                  run_last;
    } gen_cell_t;

    gen_cell_t              next_gen_q[$];
    bit                     gen_rows [3][MAX_COLS_DEF];
    logic [ROW_COUNT_W-1:0] row_count_reg;
    logic [COL_COUNT_W-1:0] col_count_reg;
    int unsigned            row_pos;
    int unsigned            col_pos;
    int unsigned            fill_slot;
    int                     fail_total;
    int                     checked_total;

    function automatic int unsigned live_width();
        if (col_count_reg < MIN_COLS)
            return MIN_COLS;
        if (col_count_reg > MAX_COLS_DEF)
            return MAX_COLS_DEF;
        return col_count_reg;
    endfunction

    function automatic int unsigned live_height();
        if (row_count_reg < 1)
            return 1;
        if (row_count_reg > MAX_ROWS_DEF)
            return MAX_ROWS_DEF;
        return row_count_reg;
    endfunction

    function automatic void rewind_block();
        row_pos   = 0;
        col_pos   = 0;
        fill_slot = 0;
    endfunction

    // neighbour count on the torus, then survival or birth
    function automatic bit next_state(int unsigned upper, int unsigned centre,
                                      int unsigned lower, int unsigned col,
                                      int unsigned width);
        int unsigned west;
        int unsigned east;
        int unsigned n;
        west = (col == 0) ? width - 1 : col - 1;
        east = (col + 1 >= width) ? 0 : col + 1;
        n = gen_rows[upper][west] + gen_rows[upper][col] + gen_rows[upper][east]
          + gen_rows[centre][west] + gen_rows[centre][east]
          + gen_rows[lower][west] + gen_rows[lower][col] + gen_rows[lower][east];
        if (gen_rows[centre][col])
            return (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
        return n == BIRTH_COUNT;
    endfunction

    task automatic take_cell(bit cell_bit);
        int unsigned width;
        int unsigned height;
        int unsigned c;
        int unsigned r;
        int unsigned lower;
        int unsigned centre;
        int unsigned upper;
        int unsigned targets[$];
        gen_cell_t   exp_cell;
        width  = live_width();
        height = live_height();
        c      = (col_pos > width - 1) ? width - 1 : col_pos;
        r      = row_pos;
        lower  = fill_slot;
        centre = (fill_slot + 2) % 3;
        upper  = (fill_slot + 1) % 3;
        gen_rows[lower][c] = cell_bit;

        // one column behind the input, the wrap adds the last column and column 0
        if (r >= 2)
        begin
            if (c >= 2)
                targets.push_back(c - 1);
            if (c == width - 1)
            begin
                targets.push_back(width - 1);
                targets.push_back(0);
            end
        end
        for (int k = 0; k < targets.size(); k++)
        begin
            exp_cell.next_alive = next_state(upper, centre, lower, targets[k], width);
            exp_cell.row        = CELL_ROW_W'(r - 1);
            exp_cell.col        = CELL_COL_W'(targets[k]);
            exp_cell.run_last   = (k == targets.size() - 1);
            next_gen_q.push_back(exp_cell);
        end

        if (c >= width - 1)
        begin
            col_pos   = 0;
            row_pos   = (r >= height + 1) ? 0 : r + 1;
            fill_slot = (fill_slot >= 2) ? 0 : fill_slot + 1;
        end
        else
            col_pos = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gen_cell_t want;
        if (!rst_n)
        begin
            row_count_reg = ROW_COUNT_W'(ROW_COUNT_RST);
            col_count_reg = COL_COUNT_W'(COL_COUNT_RST);
            rewind_block();
            next_gen_q.delete();
            fail_total      = 0;
            checked_total   = 0;
            mismatch_count  <= 0;
            results_waiting <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_total++;
                if (next_gen_q.size() == 0)
                begin
                    fail_total++;
                    $error("result with nothing expected: row %0d col %0d next_alive %0b",
                           cell_row, cell_col, next_alive);
                end
                else
                begin
                    want = next_gen_q.pop_front();
                    if (next_alive !== want.next_alive)
                    begin
                        fail_total++;
                        $error("next_alive: expected %0b, got %0b", want.next_alive, next_alive);
                    end
                    if (cell_row !== want.row)
                    begin
                        fail_total++;
                        $error("cell_row: expected %0d, got %0d", want.row, cell_row);
                    end
                    if (cell_col !== want.col)
                    begin
                        fail_total++;
                        $error("cell_col: expected %0d, got %0d", want.col, cell_col);
                    end
                    if (run_last !== want.run_last)
                    begin
                        fail_total++;
                        $error("run_last: expected %0b, got %0b", want.run_last, run_last);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_COUNT)
                begin
                    row_count_reg = cfg_data[ROW_COUNT_W-1:0];
                    rewind_block();
                end
                else if (cfg_index == REG_COL_COUNT)
                begin
                    col_count_reg = cfg_data[COL_COUNT_W-1:0];
                    rewind_block();
                end
            end

            if (in_valid && !in_stall)
                take_cell(alive);

            mismatch_count  <= fail_total;
            results_waiting <= next_gen_q.size();
            results_checked <= checked_total;
        end
    end

endmodule

@@ bench/tb_life_cellular_automaton_step_core.sv @@
// ----------------------------------------------------------------------------
// tb_life_cellular_automaton_step_core: stimulus and verdict for the life step core
// streams blocks of cells through the core under many row and column settings,
// from the smallest torus to the opening rows at the largest rows and columns, with
// random idle and stall gaps on both channels; a checker beside the core predicts
// and compares
// ----------------------------------------------------------------------------
module tb_life_cellular_automaton_step_core;
    timeunit 1ns;
    timeprecision 1ps;
    import life_pkg::*;

    // index past the register list, writes to it must leave the stream alone
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(15);

    localparam int SETTLE_CYCLES = 8;      // covers the core's stage 1, stage 2 and output registers, plus margin
    localparam int QUIET_LIMIT   = 2000;   // cycles without any handshake before giving up
    localparam int RANDOM_CELLS  = 200;
    localparam int TAIL_CELLS    = 24;     // opening cells of each of the two largest blocks

    // three-row torus: row above alive in column 0, centre row alive in columns 0 and 1,
    // so both live cells see two neighbours and the dead one sees three
    localparam bit [0:8] SEED_BLOCK = 9'b100_110_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   alive;
    logic                   out_valid;
    logic                   out_stall;
    logic                   next_alive;
    logic [CELL_ROW_W-1:0]  cell_row;
    logic [CELL_COL_W-1:0]  cell_col;
    logic                   run_last;

    int          mismatch_count;
    int          results_waiting;
    int          results_checked;
    bit          calm;                      // when set neither side idles
    int          cells_fed;
    int          reg_writes;
    int unsigned rows_set = ROW_COUNT_RST;  // register values as written, before clamping
    int unsigned cols_set = COL_COUNT_RST;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    life_cellular_automaton_step_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .alive      (alive),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .run_last   (run_last)
    );

    life_step_checker gen_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .alive           (alive),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_alive      (next_alive),
        .cell_row        (cell_row),
        .cell_col        (cell_col),
        .run_last        (run_last),
        .mismatch_count  (mismatch_count),
        .results_waiting (results_waiting),
        .results_checked (results_checked)
    );

    // cells in one whole block: halo row, interior rows, halo row
    function automatic int unsigned block_cells();
        int unsigned h;
        int unsigned w;
        h = (rows_set < 1) ? 1 : (rows_set > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_set;
        w = (cols_set < MIN_COLS) ? MIN_COLS
          : (cols_set > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_set;
        return (h + 2) * w;
    endfunction

    // hold the input off until the checker has seen every result it expects;
    // the first edge lets the count from the last accepted item settle
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_waiting != 0);
    endtask

    // one cell item, after a random idle gap; valid stays up into the next item
    task automatic feed_cell(bit cell_bit);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        alive    <= cell_bit;
        do
            @(posedge clk);
        while (in_stall);
        cells_fed++;
    endtask

    // a run of random cells at the given live percentage, with the odd full drain
    task automatic feed_run(int unsigned count, int unsigned density);
        for (int unsigned i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_results();
            feed_cell($urandom_range(0, 99) < density);
        end
    endtask

    // register writes only once the core has gone quiet; the settle time covers
    // cells still in flight that give no result
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == REG_ROW_COUNT)
            rows_set = val[ROW_COUNT_W-1:0];
        else if (idx == REG_COL_COUNT)
            cols_set = val[COL_COUNT_W-1:0];
    endtask

    // result side: a random stall before each result, none while calm
    initial
    begin
        int unsigned hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // watchdog: any handshake on any channel counts as progress
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int unsigned span;
        int unsigned count;
        int unsigned pick;
        int unsigned random_cells;
        bit          first_pass;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        alive     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the smallest torus, both registers below their range
        write_reg(REG_ROW_COUNT, '0);
        write_reg(REG_COL_COUNT, CFG_DATA_W'(2));

        // every cell alive: eight neighbours each, the interior row dies out;
        // halfway through, a write to the spare index must not rewind the block
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                write_reg(REG_SPARE, '1);
            feed_cell(1'b1);
        end

        // straight on into the next block with no write: survival and birth
        for (int i = 0; i < 9; i++)
            feed_cell(SEED_BLOCK[i]);
        wait_results();

        // two cells into a block, then a register write rewinds to the top halo row
        feed_cell(1'b1);
        feed_cell(1'b0);
        write_reg(REG_COL_COUNT, CFG_DATA_W'(1));

        // random part: mostly whole blocks with random content, some cut short;
        // the first pass keeps the rewound setting to show the rewind took hold
        first_pass   = 1'b1;
        random_cells = 0;
        while (random_cells < RANDOM_CELLS)
        begin
            if (!first_pass)
            begin
                pick = $urandom_range(0, 7);
                if (pick != 0)
                    write_reg(REG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, 5)));
                if (pick != 1)
                    write_reg(REG_COL_COUNT, CFG_DATA_W'($urandom_range(0, 9)));
            end
            first_pass = 1'b0;
            calm = ($urandom_range(0, 3) == 0);
            span = block_cells();
            if ($urandom_range(0, 4) != 0)
                count = span * $urandom_range(1, 2);
            else
                count = $urandom_range(1, span - 1);
            if (count > RANDOM_CELLS - random_cells)
                count = RANDOM_CELLS - random_cells;
            feed_run(count, $urandom_range(10, 70));
            random_cells += count;
        end
        calm = 1'b0;

        // deepest block: row register all ones, clamped to the largest row count
        write_reg(REG_ROW_COUNT, '1);
        write_reg(REG_COL_COUNT, CFG_DATA_W'(MIN_COLS));
        feed_run(TAIL_CELLS, 40);

        // widest block: column register all ones, clamped to the largest width
        write_reg(REG_ROW_COUNT, CFG_DATA_W'(1));
        write_reg(REG_COL_COUNT, '1);
        feed_run(TAIL_CELLS, 40);

        // drain, then give the core time to show any stray result
        wait_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("fed %0d cells through %0d register writes, %0d result cells compared",
                 cells_fed, reg_writes, results_checked);
        $display("whole and cut blocks from a one-row three-column torus upward, plus the");
        $display("opening rows of blocks clamped to 1024 rows and to 2048 columns");
        if (mismatch_count == 0 && results_waiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ life_cellular_automaton_step_core.f @@
+incdir+design
design/life_pkg.sv
design/life_ram.sv
design/life_cellular_automaton_step_core.sv
bench/life_step_checker.sv
bench/tb_life_cellular_automaton_step_core.sv
